// ----- hdl/sse_pkg.sv -----
// Shared constants for the selection sort engine.
// No dependencies; imported by the top level and the port checker.
package sse_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned MaxItemsDef = 16;

endpackage

// ----- hdl/selection_sort_engine_unit.sv -----
// Selection sort engine: load, sort in place, stream the sorted set. Uses sse_pkg.
// Loading accepts one transfer per cycle while busy is low. After the last item of a set,
// sorting runs with a single comparator and a single read port; output then streams
// one result a cycle, and busy stays high until the last result has been shown.
// Reset (rst_ni low, asynchronous) empties the store and clears the overflow flag.
// Results cannot be stalled; a new item waits while busy is high.
module selection_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = sse_pkg::MaxItemsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sse_pkg::DataW-1:0] value_in_i,
  input  logic                             last_in_i,
  output logic                             result_valid_o,
  output logic signed [sse_pkg::DataW-1:0] value_out_o,
  output logic                             last_out_o,
  output logic                             overflow_o
);
  import sse_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AddrW = $clog2(MAX_ITEMS);

  typedef enum logic [2:0] {
    UpcIdle, UpcPos, UpcPosRd, UpcScan, UpcSwapA, UpcSwapB, UpcOut0, UpcOut
  } upc_e;

  typedef enum logic [2:0] {
    OpIdle, OpPos, OpPosRd, OpScan, OpSwapA, OpSwapB, OpOut0, OpOut
  } op_e;

  typedef enum logic [2:0] {
    CondNever, CondAlways, CondLastIn, CondPosEnd, CondScanEnd, CondOutEnd
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold;
    upc_e  target;
  } ctrl_t;

  function automatic ctrl_t rom(input upc_e a);
    ctrl_t w;
    case (a)
      UpcIdle:  w = '{OpIdle,  CondLastIn,  1'b1, UpcPos};
      UpcPos:   w = '{OpPos,   CondPosEnd,  1'b0, UpcOut0};
      UpcPosRd: w = '{OpPosRd, CondNever,   1'b0, UpcIdle};
      UpcScan:  w = '{OpScan,  CondScanEnd, 1'b1, UpcSwapA};
      UpcSwapA: w = '{OpSwapA, CondNever,   1'b0, UpcIdle};
      UpcSwapB: w = '{OpSwapB, CondAlways,  1'b0, UpcPos};
      UpcOut0:  w = '{OpOut0,  CondNever,   1'b0, UpcIdle};
      UpcOut:   w = '{OpOut,   CondOutEnd,  1'b1, UpcIdle};
      default:  w = '{OpIdle,  CondNever,   1'b1, UpcIdle};
    endcase
    return w;
  endfunction

  logic [DataW-1:0] mem [MAX_ITEMS];

  upc_e             upc_q, upc_d;
  logic [CntW-1:0]  count_q, count_d, pos_q, pos_d, scan_q, scan_d, best_q, best_d;
  logic             ovf_q, ovf_d;
  logic [DataW-1:0] bestval_q, bestval_d, posval_q, posval_d, rdata_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [DataW-1:0] wr_data;
  logic             wr_en, accept, cond_hit;
  logic [CntW-1:0]  pos_inc, scan_inc;
  ctrl_t            cw;

  assign cw       = rom(upc_q);
  assign accept   = start && !busy;
  assign pos_inc  = pos_q + CntW'(1);
  assign scan_inc = scan_q + CntW'(1);
  assign busy     = (upc_q != UpcIdle);

  always_comb begin
    case (cw.cond)
      CondNever:   cond_hit = 1'b0;
      CondAlways:  cond_hit = 1'b1;
      CondLastIn:  cond_hit = accept && last_in_i;
      CondPosEnd:  cond_hit = (pos_inc >= count_q);
      CondScanEnd: cond_hit = (scan_inc >= count_q);
      CondOutEnd:  cond_hit = (pos_inc == count_q);
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    best_d    = best_q;
    bestval_d = bestval_q;
    posval_d  = posval_q;
    rd_addr   = pos_q[AddrW-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_q[AddrW-1:0];
    wr_data   = value_in_i;
    case (cw.op)
      OpIdle: begin
        pos_d = '0;
        if (accept) begin
          if (count_q < CntW'(MAX_ITEMS)) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      OpPos: begin
        best_d = pos_q;
        scan_d = pos_inc;
      end
      OpPosRd: begin
        bestval_d = rdata_q;
        posval_d  = rdata_q;
        rd_addr   = scan_q[AddrW-1:0];
      end
      OpScan: begin
        if ($signed(rdata_q) < $signed(bestval_q)) begin
          best_d    = scan_q;
          bestval_d = rdata_q;
        end
        scan_d  = scan_inc;
        rd_addr = scan_inc[AddrW-1:0];
      end
      OpSwapA: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AddrW-1:0];
        wr_data = bestval_q;
      end
      OpSwapB: begin
        wr_en   = 1'b1;
        wr_addr = best_q[AddrW-1:0];
        wr_data = posval_q;
        pos_d   = pos_inc;
      end
      OpOut0: begin
        pos_d   = '0;
        rd_addr = '0;
      end
      OpOut: begin
        pos_d   = pos_inc;
        rd_addr = pos_inc[AddrW-1:0];
        if (pos_inc == count_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      upc_d = cw.target;
    end else if (cw.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_e'(upc_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= UpcIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      scan_q  <= '0;
      best_q  <= '0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      scan_q  <= scan_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bestval_q <= bestval_d;
    posval_q  <= posval_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  assign result_valid_o = (cw.op == OpOut);
  assign value_out_o    = rdata_q;
  assign last_out_o     = (pos_inc == count_q);
  assign overflow_o     = ovf_q;

endmodule

// ----- hdl/sse_checker.sv -----
// Port-level checks for the selection sort engine, with its bind statement.
// Depends on sse_pkg and on selection_sort_engine_unit.
module sse_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic signed [sse_pkg::DataW-1:0] value_in_i,
  input logic                             last_in_i,
  input logic                             result_valid_o,
  input logic signed [sse_pkg::DataW-1:0] value_out_o,
  input logic                             last_out_o,
  input logic                             overflow_o
);
  import sse_pkg::*;

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside a busy phase");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_in_i) |=> !busy)
    else $error("non-final transfer left the engine busy");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_in_i) |=> busy)
    else $error("final transfer did not start sorting");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_out_o) |=> (result_valid_o && $stable(overflow_o)))
    else $error("result burst broken");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_out_o) |=> (!busy && !result_valid_o))
    else $error("engine still busy after final result");

endmodule

bind selection_sort_engine_unit sse_checker u_sse_checker (.*);

// ----- test/selection_sort_engine_unit_tb.sv -----
// Testbench for selection_sort_engine_unit: loads sets of signed values, predicts the
// sorted stream with its own selection sort, and checks every result field by field.
// Depends on sse_pkg and selection_sort_engine_unit.
`timescale 1ns / 1ps

module selection_sort_engine_unit_tb;
  import sse_pkg::*;

  localparam int unsigned StoreDepth = MaxItemsDef;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ItemsPerPhase = 123;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } load_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    overflow;
  } sorted_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [DataW-1:0] value_in_i = '0;
  logic                    last_in_i = 1'b0;
  logic                    result_valid_o;
  logic signed [DataW-1:0] value_out_o;
  logic                    last_out_o;
  logic                    overflow_o;

  load_item_t   load_q[$];
  sorted_word_t sorted_q[$];

  logic signed [DataW-1:0] shadow_store[StoreDepth];
  int unsigned             shadow_count = 0;
  logic                    shadow_overflow = 1'b0;

  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  selection_sort_engine_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_in_i    (value_in_i),
    .last_in_i     (last_in_i),
    .result_valid_o(result_valid_o),
    .value_out_o   (value_out_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Store one accepted value; on the last one, sort and queue the whole run.
  task automatic predict_sorted_run(input load_item_t item);
    int unsigned             n;
    int unsigned             best;
    logic signed [DataW-1:0] held;
    sorted_word_t            word;
    if (shadow_count < StoreDepth) begin
      shadow_store[shadow_count] = item.value;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (item.last) begin
      n = shadow_count;
      for (int unsigned pos = 0; pos + 1 < n; pos++) begin
        best = pos;
        for (int unsigned scan = pos + 1; scan < n; scan++) begin
          if (shadow_store[scan] < shadow_store[best]) best = scan;
        end
        if (best != pos) begin
          held = shadow_store[pos];
          shadow_store[pos] = shadow_store[best];
          shadow_store[best] = held;
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        word.value = shadow_store[k];
        word.last = (k + 1 == n);
        word.overflow = shadow_overflow;
        sorted_q.push_back(word);
      end
      shadow_count = 0;
      shadow_overflow = 1'b0;
    end
  endtask

  // Driver: one transfer per edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_sorted_run(load_q.pop_front());
      end
      if (load_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        value_in_i <= load_q[0].value;
        last_in_i <= load_q[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is a transfer.
  always @(posedge clk_i) begin
    sorted_word_t want;
    if (rst_ni && result_valid_o) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d", value_out_o));
      end else begin
        want = sorted_q.pop_front();
        if (value_out_o !== want.value)
          report_mismatch($sformatf("value got %0d want %0d", value_out_o, want.value));
        if (last_out_o !== want.last)
          report_mismatch($sformatf("last got %b want %b", last_out_o, want.last));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow got %b want %b", overflow_o, want.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[selection_sort_engine_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(6)) - 32'sd3;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic queue_set(input int unsigned size);
    load_item_t item;
    for (int unsigned i = 0; i < size; i++) begin
      item.value = pick_value();
      item.last = (i + 1 == size);
      load_q.push_back(item);
    end
  endtask

  task automatic queue_item(input logic signed [DataW-1:0] value, input logic last);
    load_q.push_back('{value: value, last: last});
  endtask

  initial begin
    int unsigned queued;
    int unsigned size;
    int unsigned pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-element set at the negative extreme
    queue_item(32'sh8000_0000, 1'b1);
    // extremes with a duplicate
    queue_item(32'sh7FFF_FFFF, 1'b0);
    queue_item(32'sh8000_0000, 1'b0);
    queue_item(32'sd0, 1'b0);
    queue_item(-32'sd1, 1'b0);
    queue_item(32'sd1, 1'b0);
    queue_item(32'sh8000_0000, 1'b1);
    // full store, then a dropped last item
    for (int unsigned i = 0; i < StoreDepth; i++) queue_item(32'sd5 - $signed(i), 1'b0);
    queue_item(32'sh7FFF_FFFF, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 78 : 0;
      queued = 0;
      while (queued < ItemsPerPhase) begin
        pick = $urandom_range(99);
        if (pick < 10) size = StoreDepth + $urandom_range(1, 4);
        else if (pick < 20) size = StoreDepth;
        else if (pick < 75) size = $urandom_range(1, 6);
        else size = $urandom_range(1, StoreDepth);
        queue_set(size);
        queued += size;
      end
      do @(negedge clk_i); while (load_q.size() != 0 || sorted_q.size() != 0);
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && sorted_q.size() == 0) begin
      $display("[selection_sort_engine_unit] OK");
    end else begin
      $display("[selection_sort_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
